[rtl/core/dual_stack_shared_memory_defines.svh]
// Assertion macros shared by the RTL of the dual stack block.
// No dependencies; included by files that carry concurrent checks.
`ifndef DUAL_STACK_SHARED_MEMORY_DEFINES_SVH
`define DUAL_STACK_SHARED_MEMORY_DEFINES_SVH

// expr must never hold outside reset
`define DSSM_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// ante implies cons in the same cycle
`define DSSM_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// ante implies cons in the next cycle
`define DSSM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/dssm_pkg.sv]
// Shared types, codes and constants of the dual stack block.
// No dependencies; imported by every RTL module of the block but dssm_ram.
package dssm_pkg;

   localparam int unsigned DATA_W        = 32;
   localparam int unsigned CAP_W         = 11;
   localparam int unsigned OP_W          = 2;
   localparam int unsigned STATUS_W      = 2;
   localparam int unsigned DEPTH_DEFAULT = 1024;
   localparam int unsigned QUEUE_DEPTH   = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_ONE = 2'd0,
      OP_PUSH_TWO = 2'd1,
      OP_POP_ONE  = 2'd2,
      OP_POP_TWO  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   // one classified request, front to back
   typedef struct packed {
      logic                  wr;
      logic                  rd;
      logic [CAP_W-1:0]      addr;
      logic [DATA_W-1:0]     data;
      status_type            status;
   } cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0]     value;
      status_type            status;
   } rsp_type;

   // capacity saturates at the array depth
   function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] v,
                                                  input int unsigned depth);
      logic [CAP_W-1:0] r;
      r = v;
      if (32'(v) > depth) begin
         r = CAP_W'(depth);
      end
      return r;
   endfunction

endpackage

[rtl/core/dual_stack_shared_memory.sv]
// Two LIFO stacks sharing one array.
// Request side is a queue: drive req_opcode/req_push_value with req_push while
// req_full is low. Opcodes: push stack one, push stack two, pop one, pop two.
// Result side is a queue: while rsp_empty is low, rsp_pop_value/rsp_status
// hold the oldest result; raise rsp_pop to take it. One result per request,
// in request order; pop_value is 0 for pushes and for overflow/underflow.
// csr_wdata with csr_valid sets the capacity (saturates at DEPTH) and empties
// both stacks; csr_ready is always high, write only while the block is idle.
// A request passes the request queue, the array access and the result queue.
// Throughput: one request per cycle while results are taken, set by the single
// array port (one read or write per request).
// Reset empties both stacks and the queues and restores capacity to DEPTH;
// array contents are not cleared, no clearing pass is needed.
// If the receiver stalls, the result queue and then the request queue fill
// (two entries each) and req_full rises.
// Depends on dssm_pkg, dssm_front, dssm_cmd_fifo, dssm_back.
`include "dual_stack_shared_memory_defines.svh"

module dual_stack_shared_memory #(
   parameter int unsigned DEPTH = dssm_pkg::DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [dssm_pkg::OP_W-1:0]       req_opcode,
   input  logic signed [dssm_pkg::DATA_W-1:0] req_push_value,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic signed [dssm_pkg::DATA_W-1:0] rsp_pop_value,
   output logic [dssm_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dssm_pkg::CAP_W-1:0]      csr_wdata
);
   import dssm_pkg::*;

   cmd_type           front_cmd;
   cmd_type           back_cmd;
   logic              cmd_empty;
   logic              cmd_pop;
   logic              req_fire;
   logic              rsp_fire;
   logic              csr_write;
   logic [DATA_W-1:0] back_value;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign req_fire  = req_push && !req_full;
   assign rsp_fire  = rsp_pop && !rsp_empty;

   dssm_front #(
      .DEPTH (DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_wdata      (csr_wdata),
      .req_fire       (req_fire),
      .req_opcode     (req_opcode),
      .req_push_value (req_push_value),
      .cmd            (front_cmd)
   );

   dssm_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (req_fire),
      .push_cmd (front_cmd),
      .full     (req_full),
      .pop      (cmd_pop),
      .pop_cmd  (back_cmd),
      .empty    (cmd_empty)
   );

   dssm_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd        (back_cmd),
      .cmd_empty  (cmd_empty),
      .cmd_pop    (cmd_pop),
      .rsp_fire   (rsp_fire),
      .rsp_empty  (rsp_empty),
      .rsp_value  (back_value),
      .rsp_status (rsp_status)
   );

   assign rsp_pop_value = back_value;

   `DSSM_ASSERT_IMPLIES(a_err_zero, clock, reset, !rsp_empty && rsp_status != ST_OK, rsp_pop_value == '0, "failed operation returned nonzero value")
   `DSSM_ASSERT_NEXT(a_req_queued, clock, reset, req_fire, !cmd_empty, "accepted request missing from queue")
   `DSSM_ASSERT_NEVER(a_pop_empty, clock, reset, cmd_pop && cmd_empty, "back read from empty request queue")

endmodule

[rtl/core/dssm_ram.sv]
// Generic single-port RAM, one write or read per cycle, registered read data.
// No dependencies.
module dssm_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/dssm_cmd_fifo.sv]
// Short request queue between the front and back parts.
// Depends on dssm_pkg.
module dssm_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dssm_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output dssm_pkg::cmd_type pop_cmd,
   output logic              empty
);
   import dssm_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/core/dssm_front.sv]
// Front part: capacity register, both stack counts, request classification.
// Depends on dssm_pkg.
module dssm_front #(
   parameter int unsigned DEPTH = dssm_pkg::DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [dssm_pkg::CAP_W-1:0] csr_wdata,
   input  logic                       req_fire,
   input  logic [dssm_pkg::OP_W-1:0]  req_opcode,
   input  logic [dssm_pkg::DATA_W-1:0] req_push_value,
   output dssm_pkg::cmd_type          cmd
);
   import dssm_pkg::*;

   localparam logic [CAP_W-1:0] CAP_RESET = clamp_cap(CAP_W'(DEPTH), DEPTH);

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [CAP_W-1:0] lower_ff, lower_in;
   logic [CAP_W-1:0] upper_ff, upper_in;
   logic [CAP_W:0]   used;
   logic             room;
   logic [CAP_W-1:0] lower_nxt, upper_nxt;

   assign used = {1'b0, lower_ff} + {1'b0, upper_ff};
   assign room = used < {1'b0, cap_ff};

   always_comb begin
      cmd        = '0;
      cmd.data   = req_push_value;
      cmd.status = ST_OK;
      lower_nxt  = lower_ff;
      upper_nxt  = upper_ff;
      case (op_type'(req_opcode))
         OP_PUSH_ONE: begin
            if (room) begin
               cmd.wr    = 1'b1;
               cmd.addr  = lower_ff;
               lower_nxt = lower_ff + 1'b1;
            end else begin
               cmd.status = ST_OVERFLOW;
            end
         end
         OP_PUSH_TWO: begin
            if (room) begin
               cmd.wr    = 1'b1;
               cmd.addr  = cap_ff - 1'b1 - upper_ff;
               upper_nxt = upper_ff + 1'b1;
            end else begin
               cmd.status = ST_OVERFLOW;
            end
         end
         OP_POP_ONE: begin
            if (lower_ff != '0) begin
               cmd.rd    = 1'b1;
               cmd.addr  = lower_ff - 1'b1;
               lower_nxt = lower_ff - 1'b1;
            end else begin
               cmd.status = ST_UNDERFLOW;
            end
         end
         OP_POP_TWO: begin
            // top of stack two sits at cap - count
            if (upper_ff != '0) begin
               cmd.rd    = 1'b1;
               cmd.addr  = cap_ff - upper_ff;
               upper_nxt = upper_ff - 1'b1;
            end else begin
               cmd.status = ST_UNDERFLOW;
            end
         end
         default: begin
            cmd.status = ST_OK;
         end
      endcase
   end

   always_comb begin
      cap_in   = cap_ff;
      lower_in = lower_ff;
      upper_in = upper_ff;
      if (csr_write) begin
         // new capacity empties both stacks
         cap_in   = clamp_cap(csr_wdata, DEPTH);
         lower_in = '0;
         upper_in = '0;
      end else if (req_fire) begin
         lower_in = lower_nxt;
         upper_in = upper_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         lower_ff <= '0;
         upper_ff <= '0;
      end else begin
         cap_ff   <= cap_in;
         lower_ff <= lower_in;
         upper_ff <= upper_in;
      end
   end

endmodule

[rtl/core/dssm_back.sv]
// Back part: shared array access and the result queue.
// Depends on dssm_pkg and dssm_ram.
module dssm_back #(
   parameter int unsigned DEPTH = dssm_pkg::DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dssm_pkg::cmd_type           cmd,
   input  logic                        cmd_empty,
   output logic                        cmd_pop,
   input  logic                        rsp_fire,
   output logic                        rsp_empty,
   output logic [dssm_pkg::DATA_W-1:0] rsp_value,
   output logic [dssm_pkg::STATUS_W-1:0] rsp_status
);
   import dssm_pkg::*;

   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [AW-1:0]     ram_addr;
   logic [DATA_W-1:0] ram_rdata;
   logic              ram_we;

   logic              s1_valid_ff;
   logic              s1_rd_ff;
   status_type        s1_status_ff;

   rsp_type           out_ff [QUEUE_DEPTH];
   rsp_type           land;
   logic [PTR_W-1:0]  wptr_ff, wptr_in;
   logic [PTR_W-1:0]  rptr_ff, rptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W:0]    occupancy;

   // in-flight access counts against result queue space
   assign occupancy = {1'b0, count_ff} + (CNT_W + 1)'(s1_valid_ff);
   assign cmd_pop   = !cmd_empty &&
                      ((occupancy < (CNT_W + 1)'(QUEUE_DEPTH)) || rsp_fire);
   assign ram_we    = cmd_pop && cmd.wr;
   assign ram_addr  = AW'(cmd.addr);

   dssm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (cmd.data),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd_pop;
      end
   end

   always_ff @(posedge clock) begin
      s1_rd_ff     <= cmd.rd;
      s1_status_ff <= cmd.status;
   end

   assign land.value  = s1_rd_ff ? ram_rdata : '0;
   assign land.status = s1_status_ff;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (s1_valid_ff) begin
         wptr_in = (wptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (rsp_fire) begin
         rptr_in = (rptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (s1_valid_ff && !rsp_fire) begin
         count_in = count_ff + 1'b1;
      end else if (rsp_fire && !s1_valid_ff) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         out_ff[wptr_ff] <= land;
      end
   end

   assign rsp_empty  = (count_ff == '0);
   assign rsp_value  = out_ff[rptr_ff].value;
   assign rsp_status = out_ff[rptr_ff].status;

endmodule

[dv/dssm_stack_checker.sv]
// Checker for the dual stack block: watches the request, result and capacity channels,
// predicts each result and compares it. Depends on dssm_pkg.
module dssm_stack_checker #(
   parameter int unsigned DEPTH = dssm_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  logic                          req_full,
   input  logic [dssm_pkg::OP_W-1:0]     req_opcode,
   input  logic [dssm_pkg::DATA_W-1:0]   req_push_value,
   input  logic                          rsp_empty,
   input  logic                          rsp_pop,
   input  logic [dssm_pkg::DATA_W-1:0]   rsp_pop_value,
   input  logic [dssm_pkg::STATUS_W-1:0] rsp_status,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [dssm_pkg::CAP_W-1:0]    csr_wdata,
   output int                            fail_count,
   output int                            pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import dssm_pkg::*;

   logic [DATA_W-1:0] store_image [DEPTH];
   int unsigned       lower_cnt;
   int unsigned       upper_cnt;
   int unsigned       capacity;
   rsp_type           expected_results [$];
   int                fail_total = 0;
   int                pending_total = 0;

   assign fail_count = fail_total;
   assign pending    = pending_total;

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                  input logic [DATA_W-1:0] got);
      $display("%0t ns dssm_stack_checker: %s expected %h got %h", $realtime, what, want, got);
      fail_total++;
   endtask

   // stack two entry k lives at capacity-1-k
   function automatic rsp_type predict_request(input op_type op, input logic [DATA_W-1:0] val);
      rsp_type     r;
      int unsigned used;
      r.value  = '0;
      r.status = ST_OK;
      used     = lower_cnt + upper_cnt;
      case (op)
         OP_PUSH_ONE: begin
            if (used < capacity) begin
               store_image[lower_cnt] = val;
               lower_cnt++;
            end else begin
               r.status = ST_OVERFLOW;
            end
         end
         OP_PUSH_TWO: begin
            if (used < capacity) begin
               store_image[capacity - 1 - upper_cnt] = val;
               upper_cnt++;
            end else begin
               r.status = ST_OVERFLOW;
            end
         end
         OP_POP_ONE: begin
            if (lower_cnt > 0) begin
               lower_cnt--;
               r.value = store_image[lower_cnt];
            end else begin
               r.status = ST_UNDERFLOW;
            end
         end
         default: begin
            if (upper_cnt > 0) begin
               upper_cnt--;
               r.value = store_image[capacity - 1 - upper_cnt];
            end else begin
               r.status = ST_UNDERFLOW;
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type predicted;
      if (reset) begin
         lower_cnt = 0;
         upper_cnt = 0;
         capacity  = DEPTH;
         expected_results.delete();
      end else begin
         // compare before predicting: a request taken at this edge cannot answer at it
         if (rsp_pop && !rsp_empty) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with no request outstanding", '0, rsp_pop_value);
            end else begin
               want = expected_results.pop_front();
               if (rsp_pop_value !== want.value) begin
                  report_mismatch("pop_value", want.value, rsp_pop_value);
               end
               if (rsp_status !== want.status) begin
                  report_mismatch("status", DATA_W'(want.status), DATA_W'(rsp_status));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            capacity  = (csr_wdata > DEPTH) ? DEPTH : csr_wdata;
            lower_cnt = 0;
            upper_cnt = 0;
         end
         if (req_push && !req_full) begin
            predicted        = predict_request(op_type'(req_opcode), req_push_value);
            expected_results = {expected_results, predicted};
         end
      end
      pending_total = expected_results.size();
   end

endmodule

[dv/tb_dual_stack_shared_memory.sv]
// Top of the dual stack testbench: clock, reset, request and capacity stimulus, result
// drain with stalls, and the verdict. Depends on dssm_pkg, dssm_stack_checker and the RTL.
module tb_dual_stack_shared_memory;
   timeunit 1ns;
   timeprecision 1ps;
   import dssm_pkg::*;

   localparam int unsigned HOLD_CYCLES = 200;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_push = 1'b0;
   logic                      req_full;
   logic [OP_W-1:0]           req_opcode = OP_PUSH_ONE;
   logic signed [DATA_W-1:0]  req_push_value = '0;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   logic signed [DATA_W-1:0]  rsp_pop_value;
   logic [STATUS_W-1:0]       rsp_status;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CAP_W-1:0]          csr_wdata = '0;

   int                        fail_count;
   int                        pending;
   int unsigned               idle_pct = 0;
   int unsigned               stall_pct = 0;
   int unsigned               hold_token = 0;
   int unsigned               hold_seen = 0;
   int unsigned               hold_left = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   dual_stack_shared_memory uut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_opcode     (req_opcode),
      .req_push_value (req_push_value),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata)
   );

   dssm_stack_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_opcode     (req_opcode),
      .req_push_value (req_push_value),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   // result side: random stalls, plus a long hold-off whenever the token moves
   always @(negedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      #5_000_000;
      $display("tb_dual_stack_shared_memory: errors");
      $finish;
   end

   // all tasks start and end just after a falling edge
   task automatic issue(input op_type op, input logic [DATA_W-1:0] val);
      while ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push       <= 1'b1;
      req_opcode     <= op;
      req_push_value <= val;
      do begin
         @(posedge clock);
      end while (req_full);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
   endtask

   // stacks must be idle for a capacity change
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      wait_drained();
      csr_valid <= 1'b1;
      csr_wdata <= cap;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      logic [DATA_W-1:0] v;
      case ($urandom_range(9))
         0:       v = 32'h8000_0000;
         1:       v = 32'h7fff_ffff;
         2:       v = '0;
         3:       v = '1;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic op_type pick_op(input int unsigned push_pct);
      op_type op;
      if ($urandom_range(99) < push_pct) begin
         op = ($urandom_range(1) != 0) ? OP_PUSH_TWO : OP_PUSH_ONE;
      end else begin
         op = ($urandom_range(1) != 0) ? OP_POP_TWO : OP_POP_ONE;
      end
      return op;
   endfunction

   function automatic logic [CAP_W-1:0] pick_capacity();
      logic [CAP_W-1:0] cap;
      case ($urandom_range(19))
         0:       cap = '0;
         1:       cap = CAP_W'($urandom_range(1025, 2047));
         2:       cap = CAP_W'(DEPTH_DEFAULT);
         3, 4:    cap = CAP_W'($urandom_range(7, 64));
         default: cap = CAP_W'($urandom_range(1, 6));
      endcase
      return cap;
   endfunction

   // blocks of 25 requests, each on a fresh capacity with its own push bias
   task automatic run_random(input int unsigned count);
      int unsigned push_pct;
      push_pct = 50;
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 25 == 0) begin
            write_capacity(pick_capacity());
            case ($urandom_range(2))
               0:       push_pct = 30;
               1:       push_pct = 50;
               default: push_pct = 70;
            endcase
         end
         issue(pick_op(push_pct), pick_value());
      end
   endtask

   task automatic set_idling(input int unsigned sender, input int unsigned receiver);
      idle_pct  = sender;
      stall_pct = receiver;
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed: empty, full, extremes, zero and one entry, saturation
      write_capacity(11'd3);
      issue(OP_POP_ONE, '0);
      issue(OP_POP_TWO, '1);
      issue(OP_PUSH_ONE, 32'h7fff_ffff);
      issue(OP_PUSH_TWO, 32'h8000_0000);
      issue(OP_PUSH_ONE, 32'hffff_ffff);
      issue(OP_PUSH_TWO, 32'h0000_0001);
      issue(OP_PUSH_ONE, 32'h0000_0000);
      issue(OP_POP_TWO, '0);
      issue(OP_POP_ONE, '0);
      issue(OP_POP_ONE, '0);
      issue(OP_POP_ONE, '0);
      issue(OP_POP_TWO, '0);
      write_capacity(11'd0);
      issue(OP_PUSH_ONE, 32'h1234_5678);
      issue(OP_PUSH_TWO, 32'h8765_4321);
      issue(OP_POP_ONE, '0);
      issue(OP_POP_TWO, '0);
      write_capacity(11'd1);
      issue(OP_PUSH_TWO, 32'h5a5a_5a5a);
      issue(OP_PUSH_ONE, 32'ha5a5_a5a5);
      issue(OP_POP_ONE, '0);
      // a capacity write empties both stacks
      write_capacity(11'd1);
      issue(OP_POP_TWO, '0);
      issue(OP_PUSH_TWO, 32'hdead_beef);
      issue(OP_POP_TWO, '0);

      set_idling(0, 0);
      run_random(250);
      set_idling(61, 0);
      run_random(250);
      set_idling(0, 61);
      run_random(250);
      set_idling(24, 24);
      run_random(250);

      // back-pressure: results held off while requests keep coming
      set_idling(0, 0);
      write_capacity(11'd8);
      hold_token++;
      for (int i = 0; i < 30; i++) begin
         issue(pick_op(55), pick_value());
      end

      // oversized capacity write saturates to the array depth
      write_capacity(11'h7ff);
      issue(OP_PUSH_TWO, pick_value());
      issue(OP_PUSH_TWO, pick_value());
      issue(OP_PUSH_ONE, pick_value());
      issue(OP_PUSH_TWO, pick_value());
      issue(OP_PUSH_ONE, pick_value());
      for (int i = 0; i < 6; i++) begin
         issue(pick_op(0), '0);
      end

      wait_drained();
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("tb_dual_stack_shared_memory: clean");
      end else begin
         $display("tb_dual_stack_shared_memory: errors");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/dssm_pkg.sv
rtl/core/dssm_ram.sv
rtl/core/dssm_cmd_fifo.sv
rtl/core/dssm_front.sv
rtl/core/dssm_back.sv
rtl/core/dual_stack_shared_memory.sv
dv/dssm_stack_checker.sv
dv/tb_dual_stack_shared_memory.sv
